/* rtl/viar_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package viar_pkg;

	// Access kinds
	localparam logic [2:0] OP_READ     = 3'd0;
	localparam logic [2:0] OP_WRITE    = 3'd1;
	localparam logic [2:0] OP_TICK     = 3'd2;
	localparam logic [2:0] OP_SHIFT_IN = 3'd3;
	localparam logic [2:0] OP_TAKE     = 3'd4;

	// Register map
	localparam logic [3:0] REG_PORTB    = 4'd0;
	localparam logic [3:0] REG_PORTA    = 4'd1;
	localparam logic [3:0] REG_DDRB     = 4'd2;
	localparam logic [3:0] REG_DDRA     = 4'd3;
	localparam logic [3:0] REG_T1CL     = 4'd4;
	localparam logic [3:0] REG_T1CH     = 4'd5;
	localparam logic [3:0] REG_T1LL     = 4'd6;
	localparam logic [3:0] REG_T1LH     = 4'd7;
	localparam logic [3:0] REG_T2CL     = 4'd8;
	localparam logic [3:0] REG_T2CH     = 4'd9;
	localparam logic [3:0] REG_SR       = 4'd10;
	localparam logic [3:0] REG_ACR      = 4'd11;
	localparam logic [3:0] REG_PCR      = 4'd12;
	localparam logic [3:0] REG_IFR      = 4'd13;
	localparam logic [3:0] REG_IER      = 4'd14;
	localparam logic [3:0] REG_PORTA_NH = 4'd15;

	// Flag keep masks and shift modes
	localparam logic [6:0] KEEP_PORTB = 7'h67;
	localparam logic [6:0] KEEP_PORTA = 7'h7C;
	localparam logic [6:0] KEEP_T1    = 7'h3F;
	localparam logic [6:0] KEEP_T2    = 7'h5F;
	localparam logic [2:0] MODE_OFF     = 3'd0;
	localparam logic [2:0] MODE_OUT_PHI = 3'd6;
	localparam logic [7:0] PB7_MASK     = 8'h80;

	typedef struct packed {
		logic [2:0] opcode;
		logic       device_index;
		logic [3:0] register_index;
		logic [7:0] write_data;
		logic       report_changes;
	} item_t;

	typedef struct packed {
		logic [7:0]  pa;
		logic [7:0]  pb;
		logic [7:0]  da;
		logic [7:0]  db;
		logic [6:0]  ier;
		logic [6:0]  ifr;
		logic [7:0]  sr;
		logic [7:0]  acr;
		logic [7:0]  pcr;
		logic [15:0] t1c;
		logic [15:0] t1l;
		logic [15:0] t2c;
		logic [15:0] t2l;
		logic        cb2;
	} state_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_level;
		logic       irq_changed;
		logic [7:0] port_change_mask;
		logic       port_change_is_b;
		logic       cb2_level;
		logic       cb2_notice;
	} result_t;

	localparam state_t STATE_RESET = '{
		pa: 8'h00, pb: 8'h00, da: 8'h00, db: 8'h00,
		ier: 7'h00, ifr: 7'h00, sr: 8'h00, acr: 8'h00, pcr: 8'h00,
		t1c: 16'h0000, t1l: 16'h0000, t2c: 16'h0000, t2l: 16'h0000,
		cb2: 1'b1
	};

endpackage

`default_nettype wire

/* rtl/viar_state_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module viar_state_mem #(
	parameter int DEPTH = 2,
	parameter int AW    = 1
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   rd_en,
	input  wire [AW-1:0]          rd_addr,
	output viar_pkg::state_t      rd_data,
	input  wire                   wr_en,
	input  wire [AW-1:0]          wr_addr,
	input  viar_pkg::state_t      wr_data
);

	viar_pkg::state_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	viar_pkg::state_t rd_data_q;

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Write port and registered read; unwritten entries read as reset state
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : viar_pkg::STATE_RESET;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* rtl/viar_exec.sv */
`timescale 1ns / 1ps
`default_nettype none

module viar_exec (
	input  viar_pkg::item_t   item,
	input  viar_pkg::state_t  cur,
	output viar_pkg::state_t  nxt,
	output viar_pkg::result_t res
);

	viar_pkg::state_t s;
	logic [7:0] rd;
	logic [7:0] mask;
	logic       is_b;
	logic       notice;
	logic       report;
	logic [6:0] prior_set;
	logic [6:0] after;
	logic [2:0] mode_old;
	logic [2:0] mode_new;
	logic [7:0] d;

	// Modify one adapter's state for the item
	always_comb begin
		s         = cur;
		rd        = 8'h00;
		mask      = 8'h00;
		is_b      = 1'b0;
		notice    = 1'b0;
		report    = 1'b1;
		d         = item.write_data;
		prior_set = cur.ifr & cur.ier;
		mode_old  = cur.acr[4:2];
		mode_new  = d[4:2];
		unique case (item.opcode)
			viar_pkg::OP_READ: begin
				unique case (item.register_index)
					viar_pkg::REG_PORTB: begin
						s.ifr = s.ifr & viar_pkg::KEEP_PORTB;
						rd    = cur.pb;
					end
					viar_pkg::REG_PORTA, viar_pkg::REG_PORTA_NH: rd = cur.pa;
					viar_pkg::REG_DDRB: rd = cur.db;
					viar_pkg::REG_DDRA: rd = cur.da;
					viar_pkg::REG_T1CL: begin
						s.ifr = s.ifr & viar_pkg::KEEP_T1;
						rd    = cur.t1c[7:0];
					end
					viar_pkg::REG_T1CH: rd = cur.t1c[15:8];
					viar_pkg::REG_T1LL: rd = cur.t1l[7:0];
					viar_pkg::REG_T1LH: rd = cur.t1l[15:8];
					viar_pkg::REG_T2CL: begin
						s.ifr = s.ifr & viar_pkg::KEEP_T2;
						rd    = cur.t2c[7:0];
					end
					viar_pkg::REG_T2CH: rd = cur.t2c[15:8];
					viar_pkg::REG_SR:   rd = cur.sr;
					viar_pkg::REG_ACR:  rd = cur.acr;
					viar_pkg::REG_PCR:  rd = cur.pcr;
					viar_pkg::REG_IFR:  rd = {1'b0, cur.ifr};
					default: begin
						// enable register reads with bit 7 set once anything is enabled
						rd = (cur.ier == 7'h00) ? 8'h00 : {1'b1, cur.ier};
					end
				endcase
			end
			viar_pkg::OP_WRITE: begin
				report = item.report_changes;
				unique case (item.register_index)
					viar_pkg::REG_PORTB: begin
						s.ifr = s.ifr & viar_pkg::KEEP_PORTB;
						if (item.report_changes) begin
							mask = d ^ cur.pb;
							is_b = 1'b1;
						end
						s.pb = d;
					end
					viar_pkg::REG_PORTA, viar_pkg::REG_PORTA_NH: begin
						s.ifr = s.ifr & viar_pkg::KEEP_PORTA;
						if (item.report_changes) begin
							mask = d ^ cur.pa;
						end
						s.pa = d;
					end
					viar_pkg::REG_DDRB: s.db = d;
					viar_pkg::REG_DDRA: s.da = d;
					viar_pkg::REG_T1CL, viar_pkg::REG_T1LL: s.t1l[7:0] = d;
					viar_pkg::REG_T1CH: begin
						s.t1l[15:8] = d;
						s.t1c       = {d, cur.t1l[7:0]};
						s.ifr       = s.ifr & viar_pkg::KEEP_T1;
					end
					viar_pkg::REG_T1LH: s.t1l[15:8] = d;
					viar_pkg::REG_T2CL: s.t2l[7:0] = d;
					viar_pkg::REG_T2CH: begin
						s.t2l[15:8] = d;
						s.t2c       = {d, cur.t2l[7:0]};
						s.ifr       = s.ifr & viar_pkg::KEEP_T2;
					end
					viar_pkg::REG_SR: begin
						report = 1'b1;
						s.sr   = d;
						if (mode_old == viar_pkg::MODE_OUT_PHI) begin
							if (cur.cb2) begin
								s.cb2  = 1'b0;
								notice = 1'b1;
							end
							s.ifr[2] = 1'b1;
						end
					end
					viar_pkg::REG_ACR: begin
						report = 1'b1;
						s.acr  = d;
						if (mode_new == viar_pkg::MODE_OFF) begin
							s.ifr[2] = 1'b0;
						end else if (mode_old[2] && !mode_new[2]) begin
							s.cb2  = 1'b1;
							notice = 1'b1;
						end
					end
					viar_pkg::REG_PCR: s.pcr = d;
					viar_pkg::REG_IFR: s.ifr = s.ifr & ~d[6:0];
					default: begin
						// set or clear enables by bit 7
						if (d[7]) begin
							s.ier = cur.ier | d[6:0];
						end else begin
							s.ier = cur.ier & ~d[6:0];
						end
					end
				endcase
			end
			viar_pkg::OP_TICK: begin
				if (cur.t1c == 16'h0000) begin
					if (cur.acr[6]) begin
						s.t1c = cur.t1l;
					end
					if (cur.acr[7]) begin
						s.pb = cur.pb ^ viar_pkg::PB7_MASK;
						mask = viar_pkg::PB7_MASK;
						is_b = 1'b1;
					end
					s.ifr[6] = 1'b1;
				end else begin
					s.t1c = cur.t1c - 16'd1;
				end
				if (!cur.acr[5]) begin
					if (cur.t2c != 16'h0000) begin
						s.t2c = cur.t2c - 16'd1;
					end else begin
						s.ifr[5] = 1'b1;
					end
				end
			end
			viar_pkg::OP_SHIFT_IN: begin
				if (mode_old != viar_pkg::MODE_OFF && !mode_old[2]) begin
					s.sr     = d;
					s.ifr[2] = 1'b1;
				end
			end
			viar_pkg::OP_TAKE: begin
				s.ifr[2] = 1'b1;
				s.ifr[4] = 1'b1;
				s.cb2    = cur.sr[0];
				rd       = cur.sr;
			end
			default: begin
				// unused codes leave the state alone
			end
		endcase
		after = s.ifr & s.ier;
	end

	// Build the result from the updated state
	always_comb begin
		nxt                  = s;
		res.read_data        = rd;
		res.irq_level        = |after;
		res.irq_changed      = report && (after != prior_set);
		res.port_change_mask = mask;
		res.port_change_is_b = is_b;
		res.cb2_level        = s.cb2;
		res.cb2_notice       = notice;
	end

endmodule

`default_nettype wire

/* rtl/versatile_interface_adapter_regs_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bank of NUM_ADAPTERS 6522-style interface adapters behind one access port.
// Input channel (in_valid / in_stall) carries one item: a register read or
// write, a timer tick, or a peripheral shift transfer for the adapter picked
// by device_index. Output channel (out_valid / out_stall) returns exactly one
// result item per input item, in order.
// Each adapter's state sits in one synchronous memory entry. An accepted
// item's state is read from memory at the accepting edge; the item is then
// modified and written back while its result loads into the output register
// (out_valid), unless that register still holds a stalled result. The next
// item is taken only after that write-back.
// The output register lets the next item be accepted while a result waits.
// If the receiver stalls while a second result is ready, that item holds in
// the modify stage (in_stall high) until the output register frees up.
// Reset (arst_n low) clears all adapters to their reset state (CB2 high,
// everything else zero) at once, with no clearing pass; items are accepted
// as soon as reset is released.
// An item for an adapter beyond NUM_ADAPTERS changes nothing and returns an
// all-zero result.

module versatile_interface_adapter_regs_top #(
	parameter int NUM_ADAPTERS = 2
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [2:0] opcode,
	input  wire        device_index,
	input  wire  [3:0] register_index,
	input  wire  [7:0] write_data,
	input  wire        report_changes,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] read_data,
	output logic       irq_level,
	output logic       irq_changed,
	output logic [7:0] port_change_mask,
	output logic       port_change_is_b,
	output logic       cb2_level,
	output logic       cb2_notice
);

	localparam int   AW     = (NUM_ADAPTERS > 1) ? $clog2(NUM_ADAPTERS) : 1;
	localparam logic DEV1_OK = (NUM_ADAPTERS > 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t            state_q;
	viar_pkg::item_t   item_q;
	logic              in_range_q;
	logic              in_range;
	logic              accept;
	logic              done;
	logic              out_valid_q;
	viar_pkg::result_t out_q;
	viar_pkg::result_t exec_res;
	viar_pkg::state_t  rd_state;
	viar_pkg::state_t  wr_state;
	viar_pkg::item_t   in_item;

	assign in_item  = '{opcode: opcode, device_index: device_index,
		register_index: register_index, write_data: write_data,
		report_changes: report_changes};
	assign in_range = device_index ? DEV1_OK : 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign done     = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	// Sequence each item through read then modify-write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: if (done) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q     <= in_item;
			in_range_q <= in_range;
		end
	end

	viar_state_mem #(
		.DEPTH (NUM_ADAPTERS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_addr (AW'(device_index)),
		.rd_data (rd_state),
		.wr_en   (done && in_range_q),
		.wr_addr (AW'(item_q.device_index)),
		.wr_data (wr_state)
	);

	viar_exec u_exec (
		.item (item_q),
		.cur  (rd_state),
		.nxt  (wr_state),
		.res  (exec_res)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result; drop it to zero for an absent adapter
	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= in_range_q ? exec_res : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_data        = out_q.read_data;
	assign irq_level        = out_q.irq_level;
	assign irq_changed      = out_q.irq_changed;
	assign port_change_mask = out_q.port_change_mask;
	assign port_change_is_b = out_q.port_change_is_b;
	assign cb2_level        = out_q.cb2_level;
	assign cb2_notice       = out_q.cb2_notice;

endmodule

`default_nettype wire

/* rtl/viar_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module viar_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire [2:0] opcode,
	input wire       device_index,
	input wire [3:0] register_index,
	input wire [7:0] write_data,
	input wire       report_changes,
	input wire       out_valid,
	input wire       out_stall,
	input wire [7:0] read_data,
	input wire       irq_level,
	input wire       irq_changed,
	input wire [7:0] port_change_mask,
	input wire       port_change_is_b,
	input wire       cb2_level,
	input wire       cb2_notice
);

	// An accepted item blocks the input for its modify cycle
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepting an item");

	// With the output register free, a held item leaves the modify state and the input frees up
	a_no_extra_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(in_stall && !(out_valid && out_stall)) |=> !in_stall)
		else $error("item held although output register was free");

	// A fresh result follows an accepted item, with the modify state between them
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a matching item");

	// A stalled input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(opcode)
			&& $stable(device_index) && $stable(register_index)
			&& $stable(write_data) && $stable(report_changes)))
		else $error("stalled input item changed");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_data)
			&& $stable(irq_level) && $stable(irq_changed)
			&& $stable(port_change_mask) && $stable(port_change_is_b)
			&& $stable(cb2_level) && $stable(cb2_notice)))
		else $error("stalled result changed");

endmodule

bind versatile_interface_adapter_regs_top viar_checker u_viar_checker (.*);

`default_nettype wire
